[src/positional_list_engine_core_macros.svh]
// Assertion macros of the list engine RTL
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
`define PLE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");
`define PLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check violated");
`else
`define PLE_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PLE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/ple_pkg.sv]
// Types and constants of the positional list engine
`timescale 1ns / 1ps
package ple_pkg;
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_END   = 3'd1;
  localparam logic [2:0] ACT_INS_POS   = 3'd2;
  localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [2:0] ACT_DEL_END   = 3'd4;
  localparam logic [2:0] ACT_DEL_POS   = 3'd5;
  localparam logic [2:0] ACT_QUERY     = 3'd6;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } ple_ctrl_t;
endpackage

[src/ple_cell.sv]
// One storage cell of the list row: holds an element, shifts left or right
`timescale 1ns / 1ps
module ple_cell (
  input  logic                        clk,
  input  ple_pkg::ple_ctrl_t          ctrl,
  input  logic [ple_pkg::IDX_W-1:0]   cell_idx,
  input  logic [ple_pkg::DATA_W-1:0]  left_data,
  input  logic [ple_pkg::DATA_W-1:0]  right_data,
  output logic [ple_pkg::DATA_W-1:0]  data_q,
  output logic [ple_pkg::DATA_W-1:0]  hit_data
);
  logic [ple_pkg::DATA_W-1:0] data_r;
  logic [ple_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (cell_idx > ctrl.idx) data_nxt = left_data;
      else if (cell_idx == ctrl.idx) data_nxt = ctrl.value;
    end else if (ctrl.del) begin
      if (cell_idx >= ctrl.idx) data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q   = data_r;
  assign hit_data = (cell_idx == ctrl.idx) ? data_r : '0;
endmodule

[src/positional_list_engine_core.sv]
// Top level of the positional list engine: decode, cell row and result register
`timescale 1ns / 1ps
`include "positional_list_engine_core_macros.svh"
// Holds up to CAPACITY signed 32-bit elements in a row of cells, head in cell 0.
// Each insert or delete updates the cells at once: the cells behind the target position all
// shift by one place in parallel, so one item is taken per cycle unless stalled,
// and its result beat is in the output register in the next cycle. The input is stalled
// only while a result beat is held by a stalled output. No clearing pass after reset.
module positional_list_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_removed_value,
  output logic        out_removed_valid,
  output logic [4:0]  out_element_count,
  output logic        out_is_empty
);
  localparam int CAP   = ple_pkg::CAPACITY;
  localparam int IDX_W = ple_pkg::IDX_W;
  localparam int CNT_W = ple_pkg::CNT_W;
  localparam int DW    = ple_pkg::DATA_W;
  localparam int POS_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [1:0]       status_r, status_nxt;
  logic [DW-1:0]    removed_r;
  logic             removed_valid_r;
  logic             accept;
  logic [POS_W-1:0] pos_ext, cnt_ext;
  ple_pkg::ple_ctrl_t ctrl;
  logic [DW-1:0]    removed_nxt;
  logic [DW-1:0]    cell_q   [CAP];
  logic [DW-1:0]    cell_hit [CAP];
  logic [DW-1:0]    left_d   [CAP];
  logic [DW-1:0]    right_d  [CAP];

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign pos_ext  = POS_W'(in_position);
  assign cnt_ext  = POS_W'(count_r);

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.idx   = '0;
    ctrl.value = in_value;
    status_nxt = ple_pkg::ST_DONE;
    count_nxt  = count_r;
    case (in_action)
      ple_pkg::ACT_INS_FRONT, ple_pkg::ACT_INS_END, ple_pkg::ACT_INS_POS: begin
        if (in_action == ple_pkg::ACT_INS_POS &&
            (pos_ext == '0 || pos_ext > cnt_ext + 1'b1)) begin
          status_nxt = ple_pkg::ST_BADPOS;
        end else if (cnt_ext >= POS_W'(CAP)) begin
          status_nxt = ple_pkg::ST_FULL;
        end else begin
          ctrl.ins  = accept;
          count_nxt = CNT_W'(cnt_ext + 1'b1);
          if (in_action == ple_pkg::ACT_INS_FRONT) ctrl.idx = '0;
          else if (in_action == ple_pkg::ACT_INS_END) ctrl.idx = IDX_W'(cnt_ext);
          else ctrl.idx = IDX_W'(pos_ext - 1'b1);
        end
      end
      ple_pkg::ACT_DEL_FRONT, ple_pkg::ACT_DEL_END, ple_pkg::ACT_DEL_POS: begin
        if (count_r == '0) begin
          status_nxt = ple_pkg::ST_EMPTY;
        end else if (in_action == ple_pkg::ACT_DEL_POS &&
                     (pos_ext == '0 || pos_ext > cnt_ext)) begin
          status_nxt = ple_pkg::ST_BADPOS;
        end else begin
          ctrl.del  = accept;
          count_nxt = CNT_W'(cnt_ext - 1'b1);
          if (in_action == ple_pkg::ACT_DEL_FRONT) ctrl.idx = '0;
          else if (in_action == ple_pkg::ACT_DEL_END) ctrl.idx = IDX_W'(cnt_ext - 1'b1);
          else ctrl.idx = IDX_W'(pos_ext - 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_d[g] = '0;
    end else begin : g_mid
      assign left_d[g] = cell_q[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign right_d[g] = '0;
    end else begin : g_inner
      assign right_d[g] = cell_q[g+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (IDX_W'(g)),
      .left_data  (left_d[g]),
      .right_data (right_d[g]),
      .data_q     (cell_q[g]),
      .hit_data   (cell_hit[g])
    );
  end

  always_comb begin
    removed_nxt = '0;
    for (int i = 0; i < CAP; i++) begin
      removed_nxt = removed_nxt | cell_hit[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r        <= status_nxt;
      removed_valid_r <= ctrl.del;
      removed_r       <= ctrl.del ? removed_nxt : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_removed_valid = removed_valid_r;
  assign out_element_count = 5'(count_r);
  assign out_is_empty      = (count_r == '0);

  `PLE_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= CNT_W'(CAP))
  `PLE_ASSERT_IMPL(a_removed_done, clk, rst_n, out_valid_r && removed_valid_r, status_r == ple_pkg::ST_DONE)
  `PLE_ASSERT_NEXT(a_ins_grows, clk, rst_n, ctrl.ins, count_r == CNT_W'($past(count_r) + 1'b1))
  `PLE_ASSERT_NEXT(a_del_shrinks, clk, rst_n, ctrl.del, count_r == CNT_W'($past(count_r) - 1'b1))
endmodule

[sim/positional_list_engine_core_test.sv]
// Self-checking testbench of positional_list_engine_core: directed table, then random actions
`timescale 1ns / 1ps
module positional_list_engine_core_test;
  import ple_pkg::*;

  localparam logic [2:0] ACT_SPARE      = 3'd7;
  localparam int         DIR_ROWS       = 25;
  localparam int         RANDOM_ITEMS   = 625;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 4;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] removed;
    logic        removed_valid;
    logic [4:0]  count;
    logic        empty;
  } list_result_t;

  typedef struct packed {
    logic [2:0]   action;
    logic [7:0]   position;
    logic [31:0]  value;
    logic         given;
    list_result_t result;
  } list_row_t;

  typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIXED} load_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = ACT_QUERY;
  logic [7:0]  in_position = 8'd0;
  logic [31:0] in_value = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_removed_value;
  logic        out_removed_valid;
  logic [4:0]  out_element_count;
  logic        out_is_empty;

  logic [31:0]  list_vals [CAPACITY];
  int unsigned  list_len = 0;
  list_result_t results_due [$];
  list_row_t    dir_rows [DIR_ROWS];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_pct = 0;
  int unsigned  stall_tick = 0;

  always #10 clk = ~clk;

  positional_list_engine_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_removed_valid (out_removed_valid),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty)
  );

  function automatic list_result_t apply_list_action(input logic [2:0] act,
                                                     input logic [7:0] pos,
                                                     input logic [31:0] val);
    list_result_t r;
    int unsigned  at;
    r = '0;
    r.status = ST_DONE;
    case (act)
      ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
        if (act == ACT_INS_POS && (pos < 1 || pos > list_len + 1)) begin
          r.status = ST_BADPOS;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          at = (act == ACT_INS_FRONT) ? 0 : (act == ACT_INS_END) ? list_len : pos - 1;
          for (int i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
          list_vals[at] = val;
          list_len++;
        end
      end
      ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_POS: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (act == ACT_DEL_POS && (pos < 1 || pos > list_len)) begin
          r.status = ST_BADPOS;
        end else begin
          at = (act == ACT_DEL_FRONT) ? 0 : (act == ACT_DEL_END) ? list_len - 1 : pos - 1;
          r.removed = list_vals[at];
          r.removed_valid = 1'b1;
          for (int i = at; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.count = 5'(list_len);
    r.empty = (list_len == 0);
    return r;
  endfunction

  task automatic send_beat(input logic [2:0] act, input logic [7:0] pos,
                           input logic [31:0] val, input logic given,
                           input list_result_t fixed_result);
    int unsigned  gap;
    list_result_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = apply_list_action(act, pos, val);
    results_due.push_back(given ? fixed_result : pred);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
  endtask

  // result side: stall pattern and field-by-field check
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 97 == 0) begin
      case ($urandom_range(3, 0))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        note_mismatch("unexpected beat, status", '0, out_status);
      end else begin
        want = results_due.pop_front();
        if (out_status !== want.status)
          note_mismatch("status", want.status, out_status);
        if (out_removed_value !== want.removed)
          note_mismatch("removed_value", want.removed, out_removed_value);
        if (out_removed_valid !== want.removed_valid)
          note_mismatch("removed_valid", want.removed_valid, out_removed_valid);
        if (out_element_count !== want.count)
          note_mismatch("element_count", want.count, out_element_count);
        if (out_is_empty !== want.empty)
          note_mismatch("is_empty", want.empty, out_is_empty);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL positional_list_engine_core");
      $finish;
    end
  end

  initial begin
    load_phase_t phase;
    int unsigned phase_left;
    int unsigned roll;
    logic [2:0]  act;
    logic [7:0]  pos;
    logic [31:0] val;
    phase = PH_MIXED;
    phase_left = 0;
    dir_rows = '{
      '{ACT_QUERY,     8'd0,   32'd0,         1'b1, '{ST_DONE,   32'd0, 1'b0, 5'd0, 1'b1}},
      '{ACT_DEL_FRONT, 8'd0,   32'd0,         1'b1, '{ST_EMPTY,  32'd0, 1'b0, 5'd0, 1'b1}},
      '{ACT_DEL_END,   8'd0,   32'd0,         1'b1, '{ST_EMPTY,  32'd0, 1'b0, 5'd0, 1'b1}},
      '{ACT_DEL_POS,   8'd1,   32'd0,         1'b1, '{ST_EMPTY,  32'd0, 1'b0, 5'd0, 1'b1}},
      '{ACT_INS_POS,   8'd0,   32'd5,         1'b1, '{ST_BADPOS, 32'd0, 1'b0, 5'd0, 1'b1}},
      '{ACT_INS_POS,   8'd2,   32'd5,         1'b1, '{ST_BADPOS, 32'd0, 1'b0, 5'd0, 1'b1}},
      '{ACT_INS_POS,   8'd255, 32'd5,         1'b1, '{ST_BADPOS, 32'd0, 1'b0, 5'd0, 1'b1}},
      '{ACT_INS_FRONT, 8'd0,   32'h7FFF_FFFF, 1'b1, '{ST_DONE,   32'd0, 1'b0, 5'd1, 1'b0}},
      '{ACT_DEL_POS,   8'd2,   32'd0,         1'b1, '{ST_BADPOS, 32'd0, 1'b0, 5'd1, 1'b0}},
      '{ACT_DEL_POS,   8'd0,   32'd0,         1'b1, '{ST_BADPOS, 32'd0, 1'b0, 5'd1, 1'b0}},
      '{ACT_DEL_END,   8'd0,   32'd0,         1'b1,
        '{ST_DONE, 32'h7FFF_FFFF, 1'b1, 5'd0, 1'b1}},
      '{ACT_INS_END,   8'd0,   32'h8000_0000, 1'b1, '{ST_DONE,   32'd0, 1'b0, 5'd1, 1'b0}},
      '{ACT_INS_POS,   8'd2,   32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_INS_POS,   8'd1,   32'h0000_0000, 1'b0, '0},
      '{ACT_INS_FRONT, 8'd0,   32'h0000_0001, 1'b0, '0},
      '{ACT_SPARE,     8'd255, 32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_INS_POS,   8'd3,   32'h1234_5678, 1'b0, '0},
      '{ACT_DEL_POS,   8'd3,   32'd0,         1'b0, '0},
      '{ACT_DEL_POS,   8'd5,   32'd0,         1'b0, '0},
      '{ACT_DEL_FRONT, 8'd0,   32'd0,         1'b0, '0},
      '{ACT_DEL_END,   8'd0,   32'd0,         1'b0, '0},
      '{ACT_DEL_POS,   8'd1,   32'd0,         1'b0, '0},
      '{ACT_DEL_FRONT, 8'd0,   32'd0,         1'b0, '0},
      '{ACT_QUERY,     8'd0,   32'd0,         1'b0, '0},
      '{ACT_INS_POS,   8'd1,   32'hA5A5_A5A5, 1'b0, '0}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++)
      send_beat(dir_rows[r].action, dir_rows[r].position, dir_rows[r].value,
                dir_rows[r].given, dir_rows[r].result);

    // phases lean towards filling or draining so that full and empty are both reached
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase = load_phase_t'($urandom_range(PH_MIXED, PH_GROW));
        phase_left = $urandom_range(40, 8);
      end
      phase_left--;
      roll = $urandom_range(99, 0);
      case (phase)
        PH_GROW:
          act = (roll < 75) ? 3'($urandom_range(ACT_INS_POS, ACT_INS_FRONT)) :
                (roll < 92) ? 3'($urandom_range(ACT_DEL_POS, ACT_DEL_FRONT)) : ACT_QUERY;
        PH_SHRINK:
          act = (roll < 75) ? 3'($urandom_range(ACT_DEL_POS, ACT_DEL_FRONT)) :
                (roll < 92) ? 3'($urandom_range(ACT_INS_POS, ACT_INS_FRONT)) : ACT_QUERY;
        default:
          act = 3'($urandom_range(ACT_SPARE, ACT_INS_FRONT));
      endcase
      roll = $urandom_range(99, 0);
      if (roll < 10)
        pos = 8'($urandom_range(255, 0));
      else if (roll < 15)
        pos = 8'd0;
      else if (roll < 22)
        pos = 8'(list_len + ((act == ACT_INS_POS) ? 2 : 1));
      else if (act == ACT_DEL_POS && list_len != 0)
        pos = 8'($urandom_range(list_len, 1));
      else
        pos = 8'($urandom_range(list_len + 1, 1));
      roll = $urandom_range(99, 0);
      if (roll < 3)
        val = 32'h7FFF_FFFF;
      else if (roll < 6)
        val = 32'h8000_0000;
      else if (roll < 9)
        val = 32'hFFFF_FFFF;
      else if (roll < 12)
        val = 32'd0;
      else
        val = $urandom;
      send_beat(act, pos, val, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS positional_list_engine_core");
    else
      $display("FAIL positional_list_engine_core");
    $finish;
  end
endmodule
